// ----- design/srpp_pkg.sv -----
// ----------------------------------------------------------------------------
// srpp_pkg
// Shared types and codes for the sample ramp PWM player.
// ----------------------------------------------------------------------------
package srpp_pkg;

    // Input item kinds, carried on s_tuser
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    // Ramp direction codes
    localparam logic [1:0] DIR_HOLD = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd3;

    // Full-scale numerator for the step spacing
    localparam logic [7:0] FULL_SCALE = 8'd255;

    // Restoring divider: one quotient bit per cycle over an 8-bit dividend
    localparam int         DIV_CNT_W = 3;
    localparam logic [2:0] DIV_LAST  = 3'd7;

    // Divider status as seen by the sequencer
    typedef struct packed {
        logic       done;
        logic [7:0] quotient;
    } srpp_div_status_t;

endpackage

// ----- design/srpp_ram.sv -----
// ----------------------------------------------------------------------------
// srpp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module srpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/srpp_divider.sv -----
// ----------------------------------------------------------------------------
// srpp_divider
// Shared restoring divider: 8-bit dividend, one quotient bit per cycle.
// Forms the ramp step spacing for each segment.
// ----------------------------------------------------------------------------
module srpp_divider #(
    parameter int DIVISOR_W = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [7:0]                       dividend,
    input  logic [DIVISOR_W-1:0]             divisor,
    output srpp_pkg::srpp_div_status_t       status
);

    localparam int CW = (DIVISOR_W > 9) ? DIVISOR_W : 9;

    logic [7:0]                     quo_reg, quo_next;
    logic [7:0]                     rem_reg, rem_next;
    logic [DIVISOR_W-1:0]           dvs_reg, dvs_next;
    logic [srpp_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;

    logic [8:0]    trial;
    logic [CW-1:0] trial_ext;
    logic [CW-1:0] dvs_ext;
    logic [CW-1:0] diff_ext;
    logic          fits;

    // One trial subtraction per cycle
    always_comb begin
        trial     = {rem_reg, quo_reg[7]};
        trial_ext = CW'(trial);
        dvs_ext   = CW'(dvs_reg);
        diff_ext  = trial_ext - dvs_ext;
        fits      = (trial_ext >= dvs_ext);
    end

    // Sequencing of the steps
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = 8'd0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[6:0], fits};
            rem_next = fits ? diff_ext[7:0] : trial[7:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == srpp_pkg::DIV_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign status.done     = done_reg;
    assign status.quotient = quo_reg;

endmodule

// ----- design/sample_ramp_pwm_player.sv -----
// ----------------------------------------------------------------------------
// sample_ramp_pwm_player
// Plays a ring of stored 8-bit samples as a PWM duty level, with a linear
// 256-tick ramp between consecutive samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): s_tuser selects the kind of item (write sample,
//   start playback, timer tick); s_tdata carries position and sample value.
//   Every accepted transfer yields exactly one result transfer on m_*:
//   m_tdata is the duty level (0 while stopped), m_tuser is the playing flag.
//   Items are worked one at a time; s_tready is high only while idle.
//   Writes, plain ticks and stray kinds go straight to the emit state; a
//   start, or a tick at a segment boundary, reads the sample and plans
//   the new ramp, using the shared 8-step restoring divider unless the new
//   segment is flat. The divider forms 255 / |b - a| per segment, and the
//   sample RAM read is registered. Positions wrap onto the ring through a
//   small lookup.
//   A result waits in the output register while m_tready is low; one more
//   item may be taken, its result then holds in the emit state and no new
//   item is taken until the waiting one is moved.
//   Reset (aresetn low, synchronous) stops playback and clears all ramp
//   state; sample RAM contents are undefined until written.
// ----------------------------------------------------------------------------
module sample_ramp_pwm_player #(
    parameter int SAMPLE_COUNT = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [6:0] position, [14:7] sample_value
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] duty_level
    output logic [0:0]  m_tuser    // [0] playing
);

    localparam int AW       = $clog2(SAMPLE_COUNT);
    localparam int POS_SPAN = 128;   // positions a 7-bit field can name
    localparam logic [AW-1:0] LAST_POS = AW'(SAMPLE_COUNT - 1);

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PLAN = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] replay_reg, replay_next;
    logic [AW-1:0] end_reg, end_next;
    logic [7:0]    sub_step_reg, sub_step_next;
    logic [7:0]    level_reg, level_next;
    logic [7:0]    step_len_reg, step_len_next;
    logic [7:0]    next_step_reg, next_step_next;
    logic [1:0]    dir_reg, dir_next;
    logic [7:0]    pend_level_reg, pend_level_next;
    logic [7:0]    pend_len_reg, pend_len_next;
    logic [1:0]    pend_dir_reg, pend_dir_next;
    logic [7:0]    prev_reg, prev_next;
    logic          running_reg, running_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [7:0]    m_tdata_reg, m_tdata_next;
    logic          m_tuser_reg, m_tuser_next;

    logic          div_start;
    logic [7:0]    div_divisor;
    srpp_pkg::srpp_div_status_t div_status;

    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic [AW-1:0] s_pos;
    logic [AW-1:0] adv_pos;
    logic [7:0]    target;

    // Ring address of a 7-bit position, as a constant lookup
    function automatic logic [AW-1:0] wrap_pos(logic [6:0] pos);
        logic [AW-1:0] addr;
        int            wrapped;
        addr    = '0;
        wrapped = 0;
        for (int i = 0; i < POS_SPAN; i++) begin
            if (pos == 7'(i)) begin
                addr = AW'(wrapped);
            end
            wrapped = (wrapped == SAMPLE_COUNT - 1) ? 0 : wrapped + 1;
        end
        return addr;
    endfunction

    assign s_pos   = wrap_pos(s_tdata[6:0]);
    assign adv_pos = (replay_reg == LAST_POS) ? '0 : replay_reg + 1'b1;
    assign target  = ram_rdata;

    // Sample store
    srpp_ram #(
        .WIDTH (8),
        .DEPTH (SAMPLE_COUNT)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s_pos),
        .wdata (s_tdata[14:7]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared divider
    srpp_divider #(
        .DIVISOR_W (8)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (srpp_pkg::FULL_SCALE),
        .divisor  (div_divisor),
        .status   (div_status)
    );

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        replay_next     = replay_reg;
        end_next        = end_reg;
        sub_step_next   = sub_step_reg;
        level_next      = level_reg;
        step_len_next   = step_len_reg;
        next_step_next  = next_step_reg;
        dir_next        = dir_reg;
        pend_level_next = pend_level_reg;
        pend_len_next   = pend_len_reg;
        pend_dir_next   = pend_dir_reg;
        prev_next       = prev_reg;
        running_next    = running_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        div_start       = 1'b0;
        div_divisor     = 8'd0;
        ram_we          = 1'b0;
        ram_raddr       = replay_reg;

        // result leaves on an output transfer
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EMIT;
                    case (s_tuser)
                        srpp_pkg::ACT_WRITE: begin
                            ram_we = 1'b1;
                        end
                        srpp_pkg::ACT_START: begin
                            replay_next   = s_pos;
                            end_next      = (s_pos == '0) ? LAST_POS : s_pos - 1'b1;
                            prev_next     = 8'd0;
                            sub_step_next = 8'd0;
                            level_next    = 8'd0;
                            running_next  = 1'b1;
                            ram_raddr     = s_pos;
                            state_next    = ST_PLAN;
                        end
                        srpp_pkg::ACT_TICK: begin
                            if (running_reg) begin
                                sub_step_next = sub_step_reg + 8'd1;
                                if (replay_reg == end_reg) begin
                                    running_next = 1'b0;
                                    replay_next  = '0;
                                end else if (sub_step_reg == 8'd0) begin
                                    // segment boundary: pending ramp goes live
                                    replay_next    = adv_pos;
                                    step_len_next  = pend_len_reg;
                                    next_step_next = pend_len_reg;
                                    level_next     = pend_level_reg;
                                    dir_next       = pend_dir_reg;
                                    ram_raddr      = adv_pos;
                                    state_next     = ST_PLAN;
                                end else if (sub_step_reg == next_step_reg) begin
                                    if (dir_reg == srpp_pkg::DIR_UP) begin
                                        level_next = level_reg + 8'd1;
                                    end else if (dir_reg == srpp_pkg::DIR_DOWN) begin
                                        level_next = level_reg - 8'd1;
                                    end
                                    next_step_next = next_step_reg + step_len_reg;
                                end
                            end
                        end
                        default: begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_PLAN: begin
                // plan the ramp from the previous sample to the one just read
                pend_level_next = prev_reg;
                prev_next       = target;
                if (target > prev_reg) begin
                    pend_dir_next = srpp_pkg::DIR_UP;
                    div_start     = 1'b1;
                    div_divisor   = target - prev_reg;
                    state_next    = ST_DIV;
                end else if (prev_reg > target) begin
                    pend_dir_next = srpp_pkg::DIR_DOWN;
                    div_start     = 1'b1;
                    div_divisor   = prev_reg - target;
                    state_next    = ST_DIV;
                end else begin
                    pend_dir_next = srpp_pkg::DIR_HOLD;
                    pend_len_next = 8'd0;
                    state_next    = ST_EMIT;
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    pend_len_next = div_status.quotient;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = running_reg ? level_reg : 8'd0;
                    m_tuser_next  = running_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            replay_reg     <= '0;
            end_reg        <= '0;
            sub_step_reg   <= 8'd0;
            level_reg      <= 8'd0;
            step_len_reg   <= 8'd0;
            next_step_reg  <= 8'd0;
            dir_reg        <= srpp_pkg::DIR_HOLD;
            pend_level_reg <= 8'd0;
            pend_len_reg   <= 8'd0;
            pend_dir_reg   <= srpp_pkg::DIR_HOLD;
            prev_reg       <= 8'd0;
            running_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            replay_reg     <= replay_next;
            end_reg        <= end_next;
            sub_step_reg   <= sub_step_next;
            level_reg      <= level_next;
            step_len_reg   <= step_len_next;
            next_step_reg  <= next_step_next;
            dir_reg        <= dir_next;
            pend_level_reg <= pend_level_next;
            pend_len_reg   <= pend_len_next;
            pend_dir_reg   <= pend_dir_next;
            prev_reg       <= prev_next;
            running_reg    <= running_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

// ----- verif/srpp_duty_checker.sv -----
// ----------------------------------------------------------------------------
// srpp_duty_checker
// Watches both stream channels of the sample ramp PWM player. It keeps its
// own copy of the sample ring and the ramp state, works out the duty level
// and playing flag for every accepted input transfer, and compares each
// output transfer against the oldest expectation.
// ----------------------------------------------------------------------------
module srpp_duty_checker #(
    parameter int SAMPLE_COUNT = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [6:0] position, [14:7] sample_value
    input  logic [1:0]  s_tuser,   // [1:0] action
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] duty_level
    input  logic [0:0]  m_tuser,   // [0] playing
    output int          error_count,
    output int          pending_count,
    output int          checked_count,
    output int          boundary_count,
    output int          stop_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] duty;
        logic       playing;
    } duty_result_t;

    // Shadow of the block state
    logic [7:0]  ring [SAMPLE_COUNT];
    int unsigned cur_pos;
    int unsigned last_pos;
    logic [7:0]  tick_phase;
    logic [7:0]  duty;
    logic [7:0]  span;
    logic [7:0]  due;
    logic [1:0]  dir;
    logic [7:0]  next_duty;
    logic [7:0]  next_span;
    logic [1:0]  next_dir;
    logic [7:0]  prev_target;
    logic        active;

    duty_result_t expected_duty_q [$];

    initial begin
        error_count    = 0;
        pending_count  = 0;
        checked_count  = 0;
        boundary_count = 0;
        stop_count     = 0;
    end

    function automatic void clear_ramp_state();
        cur_pos     = 0;
        last_pos    = 0;
        tick_phase  = '0;
        duty        = '0;
        span        = '0;
        due         = '0;
        dir         = srpp_pkg::DIR_HOLD;
        next_duty   = '0;
        next_span   = '0;
        next_dir    = srpp_pkg::DIR_HOLD;
        prev_target = '0;
        active      = 1'b0;
        expected_duty_q.delete();
    endfunction

    // Queue up the ramp from the previous sample to the one at cur_pos
    function automatic void plan_segment();
        logic [7:0] target;
        target    = ring[cur_pos];
        next_duty = prev_target;
        if (target > prev_target) begin
            next_dir  = srpp_pkg::DIR_UP;
            next_span = srpp_pkg::FULL_SCALE / (target - prev_target);
        end else if (prev_target > target) begin
            next_dir  = srpp_pkg::DIR_DOWN;
            next_span = srpp_pkg::FULL_SCALE / (prev_target - target);
        end else begin
            next_dir  = srpp_pkg::DIR_HOLD;
            next_span = '0;
        end
        prev_target = target;
    endfunction

    function automatic void begin_playback(logic [6:0] pos);
        cur_pos     = pos % SAMPLE_COUNT;
        last_pos    = (cur_pos != 0) ? cur_pos - 1 : SAMPLE_COUNT - 1;
        prev_target = '0;
        tick_phase  = '0;
        duty        = '0;
        plan_segment();
        active      = 1'b1;
    endfunction

    function automatic void advance_tick();
        if (!active)
            return;
        if (cur_pos != last_pos) begin
            if (tick_phase == 8'd0) begin
                // segment boundary: pending ramp goes live, next one planned
                cur_pos = (cur_pos == SAMPLE_COUNT - 1) ? 0 : cur_pos + 1;
                span    = next_span;
                due     = next_span;
                duty    = next_duty;
                dir     = next_dir;
                plan_segment();
                boundary_count++;
            end else if (tick_phase == due) begin
                if (dir == srpp_pkg::DIR_UP)
                    duty = duty + 8'd1;
                else if (dir == srpp_pkg::DIR_DOWN)
                    duty = duty - 8'd1;
                due = due + span;
            end
        end else begin
            active  = 1'b0;
            cur_pos = 0;
            stop_count++;
        end
        tick_phase = tick_phase + 8'd1;
    endfunction

    function automatic duty_result_t predict_duty(logic [1:0] act, logic [6:0] pos,
                                                  logic [7:0] value);
        duty_result_t res;
        case (act)
            srpp_pkg::ACT_WRITE: ring[pos % SAMPLE_COUNT] = value;
            srpp_pkg::ACT_START: begin_playback(pos);
            srpp_pkg::ACT_TICK:  advance_tick();
            default:             ;
        endcase
        res.duty    = active ? duty : 8'd0;
        res.playing = active;
        return res;
    endfunction

    function automatic void log_failure(string msg);
        if (error_count < 10)
            $display("%0t ns: %s", $time, msg);
        error_count++;
    endfunction

    // Predict on input transfers, compare on output transfers
    always @(posedge aclk) begin
        duty_result_t want;
        if (!aresetn) begin
            clear_ramp_state();
        end else begin
            if (s_tvalid && s_tready)
                expected_duty_q.push_back(predict_duty(s_tuser, s_tdata[6:0], s_tdata[14:7]));
            if (m_tvalid && m_tready) begin
                checked_count++;
                if (expected_duty_q.size() == 0) begin
                    log_failure($sformatf("result with nothing expected: duty=%0d playing=%0b",
                                          m_tdata, m_tuser[0]));
                end else begin
                    want = expected_duty_q.pop_front();
                    if (m_tdata !== want.duty)
                        log_failure($sformatf("duty level: expected %0d, got %0d",
                                              want.duty, m_tdata));
                    if (m_tuser[0] !== want.playing)
                        log_failure($sformatf("playing flag: expected %0b, got %0b",
                                              want.playing, m_tuser[0]));
                end
            end
        end
        pending_count = expected_duty_q.size();
    end

endmodule

// ----- verif/tb_sample_ramp_pwm_player.sv -----
// ----------------------------------------------------------------------------
// tb_sample_ramp_pwm_player
// Stimulus and verdict for the sample ramp PWM player. Loads the whole
// sample ring, runs directed corner cases, then a random mix of writes,
// starts, ticks and stray kinds, with bursty input and a stalling
// receiver. Checking is done by srpp_duty_checker.
// ----------------------------------------------------------------------------
module tb_sample_ramp_pwm_player;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         SAMPLE_COUNT    = 128;
    localparam logic [1:0] ACT_SPARE       = 2'd3;   // kind with no meaning
    localparam int         RANDOM_ITEMS    = 750;
    localparam int         LONG_HOLD       = 400;
    localparam int         DRAIN_CYCLES    = 40;
    localparam int         CYCLE_LIMIT     = 400_000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = srpp_pkg::ACT_WRITE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;

    int error_count;
    int pending_count;
    int checked_count;
    int boundary_count;
    int stop_count;

    int   items_sent    = 0;
    int   burst_left    = 0;
    int   cycles        = 0;
    logic long_hold_go  = 1'b0;

    sample_ramp_pwm_player #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    srpp_duty_checker #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) duty_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .error_count    (error_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count),
        .boundary_count (boundary_count),
        .stop_count     (stop_count)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: runs of always-ready, coin-flip and fixed stall patterns,
    // plus one long hold-off once the random phase begins
    initial begin : receiver
        int mode;
        int run_len;
        wait (aresetn);
        forever begin
            if (long_hold_go) begin
                long_hold_go = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end
            mode    = $urandom_range(0, 2);
            run_len = $urandom_range(8, 64);
            for (int k = 0; k < run_len; k++) begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= (k % 5) < 3;
                endcase
                @(negedge aclk);
            end
        end
    end

    // One input transfer; called and returns at a falling edge
    task automatic send_item(logic [1:0] act, logic [6:0] pos, logic [7:0] value);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {1'b0, value, pos};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
        // bursts of random length, idle gaps between them (sometimes none)
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap        = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
    endtask

    task automatic send_ticks(int count);
        for (int i = 0; i < count; i++)
            send_item(srpp_pkg::ACT_TICK, 7'($urandom), 8'($urandom));
    endtask

    initial begin : stimulus
        logic [7:0] value;
        int         pick;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Fill the whole ring so no playback ever reads an unwritten entry.
        // Positions 10..15 hold a run of extreme ramps: full rise, full
        // fall, a ramp that overshoots and wraps, a flat one, a near-full fall.
        for (int i = 0; i < SAMPLE_COUNT; i++) begin
            case (i)
                10:      value = 8'd255;
                11:      value = 8'd0;
                12:      value = 8'd200;
                13:      value = 8'd255;
                14:      value = 8'd255;
                15:      value = 8'd1;
                default: value = 8'($urandom);
            endcase
            send_item(srpp_pkg::ACT_WRITE, 7'(i), value);
        end

        // Directed corners
        send_item(ACT_SPARE, 7'h7F, 8'hFF);                 // stray kind while stopped
        send_item(srpp_pkg::ACT_TICK, 7'h00, 8'h00);        // tick while stopped
        send_item(srpp_pkg::ACT_START, 7'd10, 8'h00);       // first ramp 0 -> 255
        send_ticks(5);
        send_item(ACT_SPARE, 7'h2A, 8'h55);                 // stray kind while running
        send_item(srpp_pkg::ACT_WRITE, 7'h7F, 8'hFF);
        send_item(srpp_pkg::ACT_WRITE, 7'h00, 8'h00);
        send_item(srpp_pkg::ACT_START, 7'h7F, 8'h00);       // restart at top of ring
        send_ticks(3);
        send_item(srpp_pkg::ACT_START, 7'h00, 8'h00);       // end at last entry, flat ramp
        send_ticks(3);

        // Random mix, mostly ticks so ramps get well into their segments
        long_hold_go = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
                send_item(srpp_pkg::ACT_TICK, 7'($urandom), 8'($urandom));
            else if (pick < 88)
                send_item(srpp_pkg::ACT_WRITE, 7'($urandom), 8'($urandom));
            else if (pick < 96)
                send_item(srpp_pkg::ACT_START, 7'($urandom), 8'($urandom));
            else
                send_item(ACT_SPARE, 7'($urandom), 8'($urandom));
        end
        s_tvalid <= 1'b0;

        // Let everything outstanding come back, then a little longer
        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Sent %0d transfers: full ring load, directed corners and %0d random items",
                 items_sent, RANDOM_ITEMS);
        $display("with a long receiver hold; %0d results checked, %0d segments, %0d stops",
                 checked_count, boundary_count, stop_count);
        if (error_count == 0 && pending_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
